@@ rtl/ascph_pkg.sv @@
// ----------------------------------------------------------------------------
// ascph_pkg: shared constants for the sponge cipher block
// Init constants, action codes, register indexes, rate size, tags, G helpers.
// ----------------------------------------------------------------------------
package ascph_pkg;

    localparam logic [1:0] ACT_START   = 2'd0;
    localparam logic [1:0] ACT_HEADER  = 2'd1;
    localparam logic [1:0] ACT_PAYLOAD = 2'd2;
    localparam logic [1:0] ACT_FINISH  = 2'd3;

    localparam logic [1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [1:0] REG_DECRYPT  = 2'd2;

    localparam int unsigned RATE_WORDS = 12;

    localparam logic [31:0] INIT_C0 = 32'hB707322F;
    localparam logic [31:0] INIT_C1 = 32'hA0C7C90D;
    localparam logic [31:0] INIT_C2 = 32'hA3D8D930;
    localparam logic [31:0] INIT_C3 = 32'h3FA8B72C;
    localparam logic [31:0] INIT_C4 = 32'hED84EB49;
    localparam logic [31:0] INIT_C5 = 32'hEDCA4787;
    localparam logic [31:0] INIT_C6 = 32'h335463EB;
    localparam logic [31:0] INIT_C7 = 32'hF994220B;
    localparam logic [31:0] INIT_C8 = 32'hBE0BF5C9;
    localparam logic [31:0] INIT_C9 = 32'hD7C49104;

    localparam logic [31:0] TAG_HEADER  = 32'd1;
    localparam logic [31:0] TAG_PAYLOAD = 32'd2;
    localparam logic [31:0] TAG_FINAL   = 32'd8;

    typedef logic [31:0] t_word;

    function automatic t_word mix_h(input t_word x, input t_word y);
        mix_h = (x ^ y) ^ ((x & y) << 1);
    endfunction

    // column/diagonal index sets for the G step, g in 0..7
    function automatic logic [15:0] g_idx(input logic [2:0] g);
        logic [3:0] a, b, c, d;
        a = {2'b00, g[1:0]};
        if (!g[2]) begin
            b = 4'd4 + {2'b00, g[1:0]};
            c = 4'd8 + {2'b00, g[1:0]};
            d = 4'd12 + {2'b00, g[1:0]};
        end else begin
            b = 4'd4 + {2'b00, g[1:0] + 2'd1};
            c = 4'd8 + {2'b00, g[1:0] + 2'd2};
            d = 4'd12 + {2'b00, g[1:0] + 2'd3};
        end
        g_idx = {a, b, c, d};
    endfunction

endpackage

@@ rtl/aead_sponge_cipher_32_top.sv @@
// ----------------------------------------------------------------------------
// aead_sponge_cipher_32_top: 32-bit sponge AEAD, one word per beat
// Input beats start a message, absorb header words, encrypt or decrypt
// payload words, or finish and emit a four-word tag. A shared G unit
// runs one half-step of the mixing function per cycle.
//
// Usage: input channel i_valid/o_stall carries action, data and nonce.
// Output channel o_valid/i_stall carries payload words (one per payload
// beat) and tag words (four per finish beat). The input is stalled while
// an item is in work, including while its results wait on the receiver.
// A G call runs in two halves, a permutation ROUNDS rounds of G calls.
// A header or payload word passes ST_DATA (and ST_PAD on a segment end)
// and ST_OUT, plus one permutation per block opened (up to two on a
// segment end). Start takes one permutation, finish two plus four output beats.
// Reset clears the state words, rate position and configuration; the
// block is ready in the cycle after reset is released. When the receiver
// stalls, the result holds on the output ports.
// ----------------------------------------------------------------------------
module aead_sponge_cipher_32_top #(
    parameter int ROUNDS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_valid_bytes,
    input  logic        i_segment_last,
    input  logic [63:0] i_nonce,
    input  logic [63:0] i_expected_tag_low,
    input  logic [63:0] i_expected_tag_high,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_out_word,
    output logic [2:0]  o_out_bytes,
    output logic        o_out_kind,
    output logic        o_tag_ok,
    output logic        o_run_last
);
    localparam int RBITS = $clog2(ROUNDS + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PERM  = 3'd1;
    localparam logic [2:0] ST_DATA  = 3'd2;
    localparam logic [2:0] ST_PAD   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;
    localparam logic [2:0] ST_TAG   = 3'd5;

    // what follows a permutation
    localparam logic [1:0] AFT_DONE = 2'd0;
    localparam logic [1:0] AFT_DATA = 2'd1;
    localparam logic [1:0] AFT_PAD  = 2'd2;
    localparam logic [1:0] AFT_TAG  = 2'd3;

    logic [31:0] r_s [16];
    logic [2:0]  r_state;
    logic [3:0]  r_pos;
    logic        r_pend;
    logic [63:0] r_key_lo, r_key_hi;
    logic        r_dec;

    logic [1:0]  r_act;
    logic [31:0] r_data;
    logic [2:0]  r_v;
    logic        r_last;
    logic [63:0] r_exp_lo, r_exp_hi;
    logic [31:0] r_tagdom;

    logic [RBITS-1:0] r_round;
    logic [2:0]  r_g;
    logic        r_half;
    logic        r_second;
    logic [1:0]  r_after;
    logic [5:0]  r_off;
    logic        r_ok;
    logic [1:0]  r_tk;

    logic        r_ovalid;
    logic [31:0] r_oword;
    logic [2:0]  r_obytes;
    logic        r_okind, r_otag, r_olast;

    logic [15:0] gi;
    logic [3:0]  ia, ib, ic, id;
    logic [31:0] ga1, gd1, gc1, gb1, ga2, gd2, gc2, gb2;
    logic [31:0] gdx, gbx;
    logic [31:0] mask, dm, w, outw;
    logic [2:0]  veff;
    logic        in_acc, out_acc, perm_end;
    logic [5:0]  off_raw;

    assign gi = ascph_pkg::g_idx(r_g);
    assign ia = gi[15:12];
    assign ib = gi[11:8];
    assign ic = gi[7:4];
    assign id = gi[3:0];

    // one half of G: rotations 8/11 or 16/31
    always_comb begin
        ga1 = ascph_pkg::mix_h(r_s[ia], r_s[ib]);
        gdx = r_s[id] ^ ga1;
        gd1 = r_half ? {gdx[15:0], gdx[31:16]} : {gdx[7:0], gdx[31:8]};
        gc1 = ascph_pkg::mix_h(r_s[ic], gd1);
        gbx = r_s[ib] ^ gc1;
        gb1 = r_half ? {gbx[30:0], gbx[31]} : {gbx[10:0], gbx[31:11]};
        ga2 = ga1; gd2 = gd1; gc2 = gc1; gb2 = gb1;
    end

    assign veff = !r_last ? 3'd4 : (r_v > 3'd4 ? 3'd4 : r_v);
    always_comb begin
        unique case (veff)
            3'd0:    mask = 32'h0000_0000;
            3'd1:    mask = 32'h0000_00FF;
            3'd2:    mask = 32'h0000_FFFF;
            3'd3:    mask = 32'h00FF_FFFF;
            default: mask = 32'hFFFF_FFFF;
        endcase
        dm = r_data & mask;
        w  = r_s[r_pos];
        if (r_act == ascph_pkg::ACT_PAYLOAD && r_dec) outw = (w ^ dm) & mask;
        else                                          outw = (w ^ dm) & mask;
        off_raw = {r_pos, 2'b00} + {3'b000, veff};
    end

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_ovalid && !i_stall;
    assign o_stall = (r_state != ST_IDLE) || r_ovalid;
    assign perm_end = r_half && (r_g == 3'd7) && (r_round == RBITS'(ROUNDS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 16; k++) r_s[k] <= '0;
            r_state  <= ST_IDLE;
            r_pos    <= '0;
            r_pend   <= 1'b1;
            r_key_lo <= '0;
            r_key_hi <= '0;
            r_dec    <= 1'b0;
            r_ovalid <= 1'b0;
            r_round  <= '0;
            r_g      <= '0;
            r_half   <= 1'b0;
            r_second <= 1'b0;
            r_after  <= AFT_DONE;
            r_tk     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    ascph_pkg::REG_KEY_LOW:  r_key_lo <= i_cfg_data;
                    ascph_pkg::REG_KEY_HIGH: r_key_hi <= i_cfg_data;
                    ascph_pkg::REG_DECRYPT:  r_dec    <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (out_acc && r_state != ST_TAG) r_ovalid <= 1'b0;

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_act    <= i_action;
                        r_data   <= i_data_word;
                        r_v      <= i_valid_bytes;
                        r_last   <= i_segment_last;
                        r_exp_lo <= i_expected_tag_low;
                        r_exp_hi <= i_expected_tag_high;
                        r_round  <= '0;
                        r_g      <= '0;
                        r_half   <= 1'b0;
                        r_second <= 1'b0;
                        r_tagdom <= (i_action == ascph_pkg::ACT_PAYLOAD)
                                    ? ascph_pkg::TAG_PAYLOAD : ascph_pkg::TAG_HEADER;
                        priority if (i_action == ascph_pkg::ACT_START) begin
                            r_s[0]  <= i_nonce[31:0];
                            r_s[1]  <= i_nonce[63:32];
                            r_s[2]  <= ascph_pkg::INIT_C0;
                            r_s[3]  <= ascph_pkg::INIT_C1;
                            r_s[4]  <= r_key_lo[31:0];
                            r_s[5]  <= r_key_lo[63:32];
                            r_s[6]  <= r_key_hi[31:0];
                            r_s[7]  <= r_key_hi[63:32];
                            r_s[8]  <= ascph_pkg::INIT_C2;
                            r_s[9]  <= ascph_pkg::INIT_C3;
                            r_s[10] <= ascph_pkg::INIT_C4;
                            r_s[11] <= ascph_pkg::INIT_C5;
                            r_s[12] <= ascph_pkg::INIT_C6 ^ 32'd32;
                            r_s[13] <= ascph_pkg::INIT_C7 ^ 32'(ROUNDS);
                            r_s[14] <= ascph_pkg::INIT_C8 ^ 32'd1;
                            r_s[15] <= ascph_pkg::INIT_C9 ^ 32'd128;
                            r_pos   <= '0;
                            r_pend  <= 1'b1;
                            r_after <= AFT_DONE;
                            r_state <= ST_PERM;
                        end else if (i_action == ascph_pkg::ACT_FINISH) begin
                            r_s[15] <= r_s[15] ^ ascph_pkg::TAG_FINAL;
                            r_after <= AFT_TAG;
                            r_state <= ST_PERM;
                        end else if (r_pend || r_pos >= 4'(ascph_pkg::RATE_WORDS)) begin
                            r_s[15] <= r_s[15] ^ ((i_action == ascph_pkg::ACT_PAYLOAD)
                                       ? ascph_pkg::TAG_PAYLOAD : ascph_pkg::TAG_HEADER);
                            r_after <= AFT_DATA;
                            r_state <= ST_PERM;
                        end else begin
                            r_state <= ST_DATA;
                        end
                    end
                end
                ST_PERM: begin
                    r_half <= !r_half;
                    if (!r_half) begin
                        r_s[ia] <= ga1; r_s[id] <= gd1; r_s[ic] <= gc1; r_s[ib] <= gb1;
                    end else begin
                        r_s[ia] <= ga2; r_s[id] <= gd2; r_s[ic] <= gc2; r_s[ib] <= gb2;
                        r_g <= r_g + 3'd1;
                        if (r_g == 3'd7) r_round <= r_round + RBITS'(1);
                    end
                    if (perm_end) begin
                        r_round <= '0;
                        r_g     <= '0;
                        unique case (r_after)
                            AFT_DONE: r_state <= ST_IDLE;
                            AFT_DATA: begin
                                r_pos  <= '0;
                                r_pend <= 1'b0;
                                r_state <= ST_DATA;
                            end
                            AFT_PAD: begin
                                r_pos  <= '0;
                                r_pend <= 1'b0;
                                r_off  <= '0;
                                r_state <= ST_PAD;
                            end
                            default: begin
                                if (!r_second) r_second <= 1'b1;
                                else begin
                                    r_pos   <= '0;
                                    r_pend  <= 1'b1;
                                    r_tk    <= '0;
                                    r_ok    <= 1'b1;
                                    r_state <= ST_TAG;
                                end
                            end
                        endcase
                    end
                end
                ST_DATA: begin
                    if (r_act == ascph_pkg::ACT_PAYLOAD && r_dec)
                        r_s[r_pos] <= (w & ~mask) | dm;
                    else
                        r_s[r_pos] <= w ^ dm;
                    r_oword  <= outw;
                    r_obytes <= veff;
                    r_okind  <= 1'b0;
                    r_otag   <= 1'b0;
                    r_olast  <= 1'b1;
                    if (r_last) begin
                        if (off_raw >= 6'(4 * ascph_pkg::RATE_WORDS)) begin
                            r_s[15] <= r_s[15] ^ r_tagdom;
                            r_after <= AFT_PAD;
                            r_state <= ST_PERM;
                        end else begin
                            r_off   <= off_raw;
                            r_state <= ST_PAD;
                        end
                    end else begin
                        if (r_pos == 4'(ascph_pkg::RATE_WORDS - 1)) begin
                            r_pos  <= '0;
                            r_pend <= 1'b1;
                        end else r_pos <= r_pos + 4'd1;
                        r_state <= ST_OUT;
                    end
                end
                ST_PAD: begin
                    r_s[r_off[5:2]] <= r_s[r_off[5:2]] ^ (32'd1 << {r_off[1:0], 3'b000});
                    r_pos  <= '0;
                    r_pend <= 1'b1;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    // pad byte 0x80 at top of rate, then release the payload beat
                    if (r_last) r_s[11] <= r_s[11] ^ 32'h8000_0000;
                    if (r_act == ascph_pkg::ACT_PAYLOAD) r_ovalid <= 1'b1;
                    r_state <= ST_IDLE;
                end
                ST_TAG: begin
                    if (!r_ovalid || out_acc) begin
                        logic ok_n;
                        ok_n = r_ok && (r_s[{2'b00, r_tk}] == (r_tk == 2'd0 ? r_exp_lo[31:0] :
                                        r_tk == 2'd1 ? r_exp_lo[63:32] :
                                        r_tk == 2'd2 ? r_exp_hi[31:0] : r_exp_hi[63:32]));
                        r_ok     <= ok_n;
                        r_ovalid <= 1'b1;
                        r_oword  <= r_s[{2'b00, r_tk}];
                        r_obytes <= 3'd4;
                        r_okind  <= 1'b1;
                        r_otag   <= (r_tk == 2'd3) && r_dec && ok_n;
                        r_olast  <= (r_tk == 2'd3);
                        r_tk     <= r_tk + 2'd1;
                        if (r_tk == 2'd3) r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid     = r_ovalid;
    assign o_out_word  = r_oword;
    assign o_out_bytes = r_obytes;
    assign o_out_kind  = r_okind;
    assign o_tag_ok    = r_otag;
    assign o_run_last  = r_olast;
endmodule

@@ rtl/ascph_checker.sv @@
// ----------------------------------------------------------------------------
// ascph_checker: port-level checks for the sponge cipher block
// Watches the output channel and the input flow control.
// ----------------------------------------------------------------------------
module ascph_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [2:0] o_out_bytes,
    input logic       o_out_kind,
    input logic       o_tag_ok,
    input logic       o_run_last
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output beat dropped while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken while busy");

    a_tag_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_kind |-> o_out_bytes == 3'd4)
        else $error("tag beat not full width");

    a_ok_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_tag_ok |-> o_run_last && o_out_kind)
        else $error("tag_ok outside last tag beat");

    a_stall_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open with pending output");
endmodule

bind aead_sponge_cipher_32_top ascph_checker u_ascph_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_out_bytes(o_out_bytes),
    .o_out_kind(o_out_kind), .o_tag_ok(o_tag_ok), .o_run_last(o_run_last)
);
